FILE: rtl/look_at_view_matrix_unit_macros.svh
// Assertion macros for the look-at view matrix unit.
// Each use samples on posedge clk of the including module.
`ifndef LOOK_AT_VIEW_MATRIX_UNIT_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Check prop outside reset.
`define LAVM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check prop at every edge, reset included.
`define LAVM_ASSERT_NR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LAVM_ASSERT(lbl, prop, msg)
`define LAVM_ASSERT_NR(lbl, prop, msg)
`endif
`endif

FILE: rtl/lavm_pkg.sv
`timescale 1ns / 1ps
package lavm_pkg;
	localparam int DEF_FRAC_BITS = 16;
	localparam int COORD_W = 32;
	localparam int COL_W = 2;
	localparam logic [COL_W-1:0] COL_LAST = 2'd3;
	// normalizer: common scale puts the largest magnitude in [2^29, 2^30)
	localparam int NORM_W = 30;
	localparam int NORM_TOP = 29;
	localparam int SUM_W = 62;
	localparam int LEN_W = 31;

	typedef struct packed {
		logic valid;
		logic zero;
	} nflag_t;
endpackage

FILE: rtl/lavm_if.sv
`timescale 1ns / 1ps
interface lavm_cam_if import lavm_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [COORD_W-1:0] eye_x;
	logic signed [COORD_W-1:0] eye_y;
	logic signed [COORD_W-1:0] eye_z;
	logic signed [COORD_W-1:0] target_x;
	logic signed [COORD_W-1:0] target_y;
	logic signed [COORD_W-1:0] target_z;
	logic signed [COORD_W-1:0] upward_x;
	logic signed [COORD_W-1:0] upward_y;
	logic signed [COORD_W-1:0] upward_z;

	modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
		upward_x, upward_y, upward_z, input ready);
	modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
		upward_x, upward_y, upward_z, output ready);
endinterface

interface lavm_col_if import lavm_pkg::*; ();
	logic valid;
	logic ready;
	logic [COL_W-1:0] column_index;
	logic signed [COORD_W-1:0] row0_value;
	logic signed [COORD_W-1:0] row1_value;
	logic signed [COORD_W-1:0] row2_value;
	logic signed [COORD_W-1:0] row3_value;
	logic last_column;
	logic degenerate;

	modport source (output valid, column_index, row0_value, row1_value, row2_value,
		row3_value, last_column, degenerate, input ready);
	modport sink (input valid, column_index, row0_value, row1_value, row2_value,
		row3_value, last_column, degenerate, output ready);
endinterface

FILE: rtl/lavm_norm.sv
`timescale 1ns / 1ps
module lavm_norm import lavm_pkg::*; #(
	parameter int IW = 33,
	parameter int FB = DEF_FRAC_BITS,
	parameter int PW = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [IW-1:0] vec_in [3],
	input  logic [PW-1:0] pay_in,
	output nflag_t flag,
	output logic signed [FB+1:0] vec_out [3],
	output logic [PW-1:0] pay_out
);
	localparam int PSW = $clog2(IW);
	localparam int QB = FB + 1;
	localparam int NW = NORM_W + FB + 1;
	localparam int RT = SUM_W / 2;

	// stage 1: magnitudes
	logic v_s1;
	logic [IW-1:0] m_s1 [3];
	logic [2:0] neg_s1;
	logic [PW-1:0] pay_s1;
	// stage 2: leading one of the largest magnitude
	logic v_s2;
	logic [IW-1:0] m_s2 [3];
	logic [2:0] neg_s2;
	logic zero_s2;
	logic [PSW-1:0] pos_s2;
	logic [PW-1:0] pay_s2;
	logic [IW-1:0] or_w;
	logic [PSW-1:0] pos_w;
	// stage 3: common scale
	logic v_s3;
	logic [NORM_W-1:0] mn_s3 [3];
	logic [NORM_W-1:0] mn_w [3];
	logic [2:0] neg_s3;
	logic zero_s3;
	logic [PW-1:0] pay_s3;
	// stage 4: squares
	logic v_s4;
	logic [2*NORM_W-1:0] sq_s4 [3];
	logic [NORM_W-1:0] mn_s4 [3];
	logic [2:0] neg_s4;
	logic zero_s4;
	logic [PW-1:0] pay_s4;
	// root stages, index 0 holds the sum of squares
	logic rv_sk [RT+1];
	logic [SUM_W-1:0] rt_n_sk [RT+1];
	logic [SUM_W-1:0] rt_r_sk [RT+1];
	logic [NORM_W-1:0] mn_rt_sk [RT+1][3];
	logic [2:0] neg_rt_sk [RT+1];
	logic zero_rt_sk [RT+1];
	logic [PW-1:0] pay_rt_sk [RT+1];
	// divider stages, index 0 holds numerators and length
	logic [LEN_W-1:0] len_w;
	logic [NW-1:0] num_w [3];
	logic dv_sk [QB+1];
	logic [LEN_W-1:0] len_dv_sk [QB+1];
	logic [LEN_W-1:0] rem_dv_sk [QB+1][3];
	logic [QB-1:0] nlo_dv_sk [QB+1][3];
	logic [QB-1:0] quo_dv_sk [QB+1][3];
	logic [2:0] neg_dv_sk [QB+1];
	logic zero_dv_sk [QB+1];
	logic [PW-1:0] pay_dv_sk [QB+1];
	// output stage
	logic v_so;
	logic zero_so;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			rv_sk[0] <= 1'b0;
			dv_sk[0] <= 1'b0;
			v_so <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			rv_sk[0] <= v_s4;
			dv_sk[0] <= rv_sk[RT];
			v_so <= dv_sk[QB];
		end
	end

	always_comb begin
		or_w = m_s1[0] | m_s1[1] | m_s1[2];
		pos_w = '0;
		for (int b = 0; b < IW; b++) begin
			if (or_w[b]) pos_w = PSW'(b);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pos_s2 >= PSW'(NORM_TOP))
				mn_w[i] = NORM_W'(m_s2[i] >> (pos_s2 - PSW'(NORM_TOP)));
			else
				mn_w[i] = NORM_W'(m_s2[i] << (PSW'(NORM_TOP) - pos_s2));
		end
	end

	assign len_w = rt_r_sk[RT][LEN_W-1:0];

	always_comb begin
		for (int i = 0; i < 3; i++)
			num_w[i] = (NW'(mn_rt_sk[RT][i]) << FB) + NW'(len_w >> 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vec_in[i][IW-1];
				m_s1[i] <= vec_in[i][IW-1] ? $unsigned(-vec_in[i]) : $unsigned(vec_in[i]);
			end
			pay_s1 <= pay_in;

			m_s2 <= m_s1;
			neg_s2 <= neg_s1;
			zero_s2 <= (or_w == '0);
			pos_s2 <= pos_w;
			pay_s2 <= pay_s1;

			mn_s3 <= mn_w;
			neg_s3 <= neg_s2;
			zero_s3 <= zero_s2;
			pay_s3 <= pay_s2;

			for (int i = 0; i < 3; i++)
				sq_s4[i] <= (2*NORM_W)'(mn_s3[i]) * (2*NORM_W)'(mn_s3[i]);
			mn_s4 <= mn_s3;
			neg_s4 <= neg_s3;
			zero_s4 <= zero_s3;
			pay_s4 <= pay_s3;

			rt_n_sk[0] <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
			rt_r_sk[0] <= '0;
			mn_rt_sk[0] <= mn_s4;
			neg_rt_sk[0] <= neg_s4;
			zero_rt_sk[0] <= zero_s4;
			pay_rt_sk[0] <= pay_s4;

			len_dv_sk[0] <= len_w;
			for (int i = 0; i < 3; i++) begin
				rem_dv_sk[0][i] <= LEN_W'(num_w[i] >> QB);
				nlo_dv_sk[0][i] <= num_w[i][QB-1:0];
				quo_dv_sk[0][i] <= '0;
			end
			neg_dv_sk[0] <= neg_rt_sk[RT];
			zero_dv_sk[0] <= zero_rt_sk[RT];
			pay_dv_sk[0] <= pay_rt_sk[RT];

			for (int i = 0; i < 3; i++) begin
				if (zero_dv_sk[QB])
					vec_out[i] <= '0;
				else if (neg_dv_sk[QB][i])
					vec_out[i] <= -$signed({1'b0, quo_dv_sk[QB][i]});
				else
					vec_out[i] <= $signed({1'b0, quo_dv_sk[QB][i]});
			end
			zero_so <= zero_dv_sk[QB];
			pay_out <= pay_dv_sk[QB];
		end
	end

	// one root bit per stage
	for (genvar k = 0; k < RT; k++) begin : g_root
		localparam logic [SUM_W-1:0] RBIT = SUM_W'(1) << (SUM_W - 2 - 2*k);
		logic [SUM_W-1:0] trial;
		logic ge;

		always_comb begin
			trial = rt_r_sk[k] + RBIT;
			ge = (rt_n_sk[k] >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rv_sk[k+1] <= 1'b0;
			else if (en) rv_sk[k+1] <= rv_sk[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (ge) begin
					rt_n_sk[k+1] <= rt_n_sk[k] - trial;
					rt_r_sk[k+1] <= (rt_r_sk[k] >> 1) + RBIT;
				end else begin
					rt_n_sk[k+1] <= rt_n_sk[k];
					rt_r_sk[k+1] <= rt_r_sk[k] >> 1;
				end
				mn_rt_sk[k+1] <= mn_rt_sk[k];
				neg_rt_sk[k+1] <= neg_rt_sk[k];
				zero_rt_sk[k+1] <= zero_rt_sk[k];
				pay_rt_sk[k+1] <= pay_rt_sk[k];
			end
		end
	end

	// one quotient bit per stage, three lanes
	for (genvar j = 0; j < QB; j++) begin : g_div
		logic [LEN_W:0] trial [3];
		logic [2:0] ge;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				trial[i] = {rem_dv_sk[j][i], nlo_dv_sk[j][i][QB-1-j]};
				ge[i] = (trial[i] >= {1'b0, len_dv_sk[j]});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_sk[j+1] <= 1'b0;
			else if (en) dv_sk[j+1] <= dv_sk[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (ge[i])
						rem_dv_sk[j+1][i] <= LEN_W'(trial[i] - {1'b0, len_dv_sk[j]});
					else
						rem_dv_sk[j+1][i] <= LEN_W'(trial[i]);
					quo_dv_sk[j+1][i] <= {quo_dv_sk[j][i][QB-2:0], ge[i]};
				end
				nlo_dv_sk[j+1] <= nlo_dv_sk[j];
				len_dv_sk[j+1] <= len_dv_sk[j];
				neg_dv_sk[j+1] <= neg_dv_sk[j];
				zero_dv_sk[j+1] <= zero_dv_sk[j];
				pay_dv_sk[j+1] <= pay_dv_sk[j];
			end
		end
	end

	assign flag.valid = v_so;
	assign flag.zero = zero_so;
endmodule

FILE: rtl/look_at_view_matrix_unit.sv
`timescale 1ns / 1ps
//  channel  | dir | handshake     | item
//  ---------+-----+---------------+------------------------------------------------
//  camera   | in  | valid / ready | eye, target, upward xyz, signed fixed point
//  matrix   | out | valid / ready | one view matrix column, index 0..3, flags
//
//  Each camera gives four column items, one per cycle while matrix.ready is high; the
//  output register takes a new camera only once its last column is accepted.
//  Most of the pipeline depth lies in the two normalizers: each runs
//  a 31-step bit-serial square root and a (FRAC_BITS+1)-step divider, one step a stage.
//  arst_n clears all valid bits and the column counter; data registers keep no reset.
//  Stalls freeze the whole pipeline at once; it only stalls when its last stage is
//  full and the output register still has columns to deliver, so nothing drops.
`include "look_at_view_matrix_unit_macros.svh"
module look_at_view_matrix_unit import lavm_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input logic clk,
	input logic arst_n,
	lavm_cam_if.sink camera,
	lavm_col_if.source matrix
);
	localparam int FB = FRAC_BITS;
	localparam int OW = FB + 2;             // unit vector component
	localparam int DW = COORD_W + 1;        // target - eye
	localparam int PRW = OW + COORD_W;      // component times coordinate
	localparam int CW = PRW + 1;            // cross product f x up
	localparam int SFW = 2 * OW;            // component times component
	localparam int URW = SFW + 1;           // raw s x f
	localparam int DTW = PRW + 2;           // three-term dot product
	localparam int TW = PRW + 4;            // rounding headroom
	localparam int P1W = 6 * COORD_W;
	localparam int P2W = 3 * COORD_W + 3 * OW + 1;
	localparam logic signed [TW-1:0] SAT_HI = TW'(2147483647);
	localparam logic signed [TW-1:0] SAT_LO = -SAT_HI - TW'(1);
	localparam logic signed [COORD_W-1:0] ONE_FX = COORD_W'(1 << FB);

	// round half up to FB fraction bits, then clamp to 32 bits
	function automatic logic signed [COORD_W-1:0] rnd_sat(input logic signed [TW-1:0] x);
		logic signed [TW-1:0] y;
		logic signed [TW-1:0] r;
		y = x + TW'(1 << (FB - 1));
		r = y >>> FB;
		if (r > SAT_HI) r = SAT_HI;
		if (r < SAT_LO) r = SAT_LO;
		return r[COORD_W-1:0];
	endfunction

	// global advance: hold everything only while the last stage waits on the output
	logic adv;
	logic out_load;
	logic ov_q;
	logic [COL_W-1:0] col_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	// stage 1
	logic signed [DW-1:0] d_s1 [3];
	logic signed [COORD_W-1:0] eye_s1 [3];
	logic signed [COORD_W-1:0] up_s1 [3];
	// normalizer 1
	nflag_t nf1;
	logic signed [OW-1:0] f_n1 [3];
	logic [P1W-1:0] pay1_out;
	logic signed [COORD_W-1:0] eye_n1 [3];
	logic signed [COORD_W-1:0] up_n1 [3];
	// stages 2, 3
	logic signed [PRW-1:0] pr_s2 [6];
	logic signed [COORD_W-1:0] eye_s2 [3];
	logic signed [OW-1:0] f_s2 [3];
	logic zf_s2;
	logic signed [CW-1:0] c_s3 [3];
	logic signed [COORD_W-1:0] eye_s3 [3];
	logic signed [OW-1:0] f_s3 [3];
	logic zf_s3;
	// normalizer 2
	nflag_t nf2;
	logic signed [OW-1:0] s_n2 [3];
	logic [P2W-1:0] pay2_out;
	logic signed [COORD_W-1:0] eye_n2 [3];
	logic signed [OW-1:0] f_n2 [3];
	logic zf_n2;
	// stages 4..9
	logic signed [SFW-1:0] sf_s4 [6];
	logic signed [PRW-1:0] se_s4 [3];
	logic signed [PRW-1:0] fe_s4 [3];
	logic signed [OW-1:0] s_s4 [3], f_s4 [3];
	logic signed [COORD_W-1:0] eye_s4 [3];
	logic deg_s4;
	logic signed [URW-1:0] ur_s5 [3];
	logic signed [DTW-1:0] dse_s5, dfe_s5;
	logic signed [OW-1:0] s_s5 [3], f_s5 [3];
	logic signed [COORD_W-1:0] eye_s5 [3];
	logic deg_s5;
	logic signed [URW-1:0] urh_w [3];
	logic signed [OW-1:0] u_s6 [3], s_s6 [3], f_s6 [3];
	logic signed [COORD_W-1:0] eye_s6 [3];
	logic signed [COORD_W-1:0] t0_s6, t2_s6;
	logic deg_s6;
	logic signed [PRW-1:0] ue_s7 [3];
	logic signed [OW-1:0] u_s7 [3], s_s7 [3], f_s7 [3];
	logic signed [COORD_W-1:0] t0_s7, t2_s7;
	logic deg_s7;
	logic signed [DTW-1:0] due_s8;
	logic signed [OW-1:0] u_s8 [3], s_s8 [3], f_s8 [3];
	logic signed [COORD_W-1:0] t0_s8, t2_s8;
	logic deg_s8;
	logic signed [OW-1:0] u_s9 [3], s_s9 [3], f_s9 [3];
	logic signed [COORD_W-1:0] t0_s9, t1_s9, t2_s9;
	logic deg_s9;
	// output register: one array for each of rows 0..2, indexed by column
	logic signed [COORD_W-1:0] r0_q [4];
	logic signed [COORD_W-1:0] r1_q [4];
	logic signed [COORD_W-1:0] r2_q [4];
	logic deg_q;

	assign out_load = !ov_q || (matrix.ready && col_q == COL_LAST);
	assign adv = !v_s9 || out_load;
	assign camera.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s1 <= camera.valid;
			v_s2 <= nf1.valid;
			v_s3 <= v_s2;
			v_s4 <= nf2.valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// stage 1: direction from eye to target
	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1[0] <= DW'(camera.target_x) - DW'(camera.eye_x);
			d_s1[1] <= DW'(camera.target_y) - DW'(camera.eye_y);
			d_s1[2] <= DW'(camera.target_z) - DW'(camera.eye_z);
			eye_s1[0] <= camera.eye_x;
			eye_s1[1] <= camera.eye_y;
			eye_s1[2] <= camera.eye_z;
			up_s1[0] <= camera.upward_x;
			up_s1[1] <= camera.upward_y;
			up_s1[2] <= camera.upward_z;
		end
	end

	lavm_norm #(.IW(DW), .FB(FB), .PW(P1W)) u_norm_fwd (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(v_s1),
		.vec_in(d_s1),
		.pay_in({eye_s1[0], eye_s1[1], eye_s1[2], up_s1[0], up_s1[1], up_s1[2]}),
		.flag(nf1),
		.vec_out(f_n1),
		.pay_out(pay1_out)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			eye_n1[i] = $signed(pay1_out[P1W-1-i*COORD_W -: COORD_W]);
			up_n1[i] = $signed(pay1_out[3*COORD_W-1-i*COORD_W -: COORD_W]);
		end
	end

	// stages 2, 3: exact f x up
	always_ff @(posedge clk) begin
		if (adv) begin
			pr_s2[0] <= PRW'(f_n1[1]) * PRW'(up_n1[2]);
			pr_s2[1] <= PRW'(f_n1[2]) * PRW'(up_n1[1]);
			pr_s2[2] <= PRW'(f_n1[2]) * PRW'(up_n1[0]);
			pr_s2[3] <= PRW'(f_n1[0]) * PRW'(up_n1[2]);
			pr_s2[4] <= PRW'(f_n1[0]) * PRW'(up_n1[1]);
			pr_s2[5] <= PRW'(f_n1[1]) * PRW'(up_n1[0]);
			eye_s2 <= eye_n1;
			f_s2 <= f_n1;
			zf_s2 <= nf1.zero;

			c_s3[0] <= CW'(pr_s2[0]) - CW'(pr_s2[1]);
			c_s3[1] <= CW'(pr_s2[2]) - CW'(pr_s2[3]);
			c_s3[2] <= CW'(pr_s2[4]) - CW'(pr_s2[5]);
			eye_s3 <= eye_s2;
			f_s3 <= f_s2;
			zf_s3 <= zf_s2;
		end
	end

	lavm_norm #(.IW(CW), .FB(FB), .PW(P2W)) u_norm_right (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(v_s3),
		.vec_in(c_s3),
		.pay_in({eye_s3[0], eye_s3[1], eye_s3[2], f_s3[0], f_s3[1], f_s3[2], zf_s3}),
		.flag(nf2),
		.vec_out(s_n2),
		.pay_out(pay2_out)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			eye_n2[i] = $signed(pay2_out[P2W-1-i*COORD_W -: COORD_W]);
			f_n2[i] = $signed(pay2_out[3*OW-i*OW -: OW]);
		end
		zf_n2 = pay2_out[0];
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			urh_w[i] = ur_s5[i] + URW'(1 << (FB - 1));
	end

	// stages 4..9: u = s x f, then the three translation dot products
	always_ff @(posedge clk) begin
		if (adv) begin
			sf_s4[0] <= SFW'(s_n2[1]) * SFW'(f_n2[2]);
			sf_s4[1] <= SFW'(s_n2[2]) * SFW'(f_n2[1]);
			sf_s4[2] <= SFW'(s_n2[2]) * SFW'(f_n2[0]);
			sf_s4[3] <= SFW'(s_n2[0]) * SFW'(f_n2[2]);
			sf_s4[4] <= SFW'(s_n2[0]) * SFW'(f_n2[1]);
			sf_s4[5] <= SFW'(s_n2[1]) * SFW'(f_n2[0]);
			for (int i = 0; i < 3; i++) begin
				se_s4[i] <= PRW'(s_n2[i]) * PRW'(eye_n2[i]);
				fe_s4[i] <= PRW'(f_n2[i]) * PRW'(eye_n2[i]);
			end
			s_s4 <= s_n2;
			f_s4 <= f_n2;
			eye_s4 <= eye_n2;
			deg_s4 <= zf_n2 | nf2.zero;

			ur_s5[0] <= URW'(sf_s4[0]) - URW'(sf_s4[1]);
			ur_s5[1] <= URW'(sf_s4[2]) - URW'(sf_s4[3]);
			ur_s5[2] <= URW'(sf_s4[4]) - URW'(sf_s4[5]);
			dse_s5 <= DTW'(se_s4[0]) + DTW'(se_s4[1]) + DTW'(se_s4[2]);
			dfe_s5 <= DTW'(fe_s4[0]) + DTW'(fe_s4[1]) + DTW'(fe_s4[2]);
			s_s5 <= s_s4;
			f_s5 <= f_s4;
			eye_s5 <= eye_s4;
			deg_s5 <= deg_s4;

			for (int i = 0; i < 3; i++)
				u_s6[i] <= OW'(urh_w[i] >>> FB);
			t0_s6 <= rnd_sat(-TW'(dse_s5));
			t2_s6 <= rnd_sat(TW'(dfe_s5));
			s_s6 <= s_s5;
			f_s6 <= f_s5;
			eye_s6 <= eye_s5;
			deg_s6 <= deg_s5;

			for (int i = 0; i < 3; i++)
				ue_s7[i] <= PRW'(u_s6[i]) * PRW'(eye_s6[i]);
			u_s7 <= u_s6;
			s_s7 <= s_s6;
			f_s7 <= f_s6;
			t0_s7 <= t0_s6;
			t2_s7 <= t2_s6;
			deg_s7 <= deg_s6;

			due_s8 <= DTW'(ue_s7[0]) + DTW'(ue_s7[1]) + DTW'(ue_s7[2]);
			u_s8 <= u_s7;
			s_s8 <= s_s7;
			f_s8 <= f_s7;
			t0_s8 <= t0_s7;
			t2_s8 <= t2_s7;
			deg_s8 <= deg_s7;

			t1_s9 <= rnd_sat(-TW'(due_s8));
			u_s9 <= u_s8;
			s_s9 <= s_s8;
			f_s9 <= f_s8;
			t0_s9 <= t0_s8;
			t2_s9 <= t2_s8;
			deg_s9 <= deg_s8;
		end
	end

	// output register: advance the column on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			col_q <= '0;
		end else if (out_load) begin
			ov_q <= v_s9;
			col_q <= '0;
		end else if (matrix.ready) begin
			col_q <= col_q + COL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && v_s9) begin
			for (int i = 0; i < 3; i++) begin
				r0_q[i] <= COORD_W'(s_s9[i]);
				r1_q[i] <= COORD_W'(u_s9[i]);
				r2_q[i] <= COORD_W'(-f_s9[i]);
			end
			r0_q[3] <= t0_s9;
			r1_q[3] <= t1_s9;
			r2_q[3] <= t2_s9;
			deg_q <= deg_s9;
		end
	end

	assign matrix.valid = ov_q;
	assign matrix.column_index = col_q;
	assign matrix.row0_value = r0_q[col_q];
	assign matrix.row1_value = r1_q[col_q];
	assign matrix.row2_value = r2_q[col_q];
	assign matrix.row3_value = (col_q == COL_LAST) ? ONE_FX : '0;
	assign matrix.last_column = (col_q == COL_LAST);
	assign matrix.degenerate = deg_q;

	`LAVM_ASSERT(a_col_step, matrix.valid && matrix.ready && !matrix.last_column |=> matrix.valid && (matrix.column_index == $past(matrix.column_index) + 2'd1), "column sequence broken")
	`LAVM_ASSERT(a_one_fx, matrix.valid && matrix.last_column |-> matrix.row3_value == ONE_FX, "row 3 of translation column is not one")
	`LAVM_ASSERT(a_stall_cause, !camera.ready |-> v_s9 && ov_q, "input stalled without a full pipeline end")
	`LAVM_ASSERT_NR(a_rst_idle, !arst_n |-> !matrix.valid && col_q == 2'd0, "output active in reset")
endmodule
